### rtl/core/indexed_byte_list_engine_top_defines.svh
// Assertion macros used by the list engine sequencer.
`ifndef INDEXED_BYTE_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_BYTE_LIST_ENGINE_TOP_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define IBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define IBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/ibl_pkg.sv
// Package: types, codes and sizes of the list engine.
package ibl_pkg;
	localparam int DEF_CAPACITY = 32;
	localparam int MAX_RESULTS  = 32;

	localparam logic [3:0] OP_SIZE     = 4'd0;
	localparam logic [3:0] OP_GET      = 4'd1;
	localparam logic [3:0] OP_EDIT     = 4'd2;
	localparam logic [3:0] OP_INS_TAIL = 4'd3;
	localparam logic [3:0] OP_INS_HEAD = 4'd4;
	localparam logic [3:0] OP_INS_AT   = 4'd5;
	localparam logic [3:0] OP_RM_TAIL  = 4'd6;
	localparam logic [3:0] OP_RM_HEAD  = 4'd7;
	localparam logic [3:0] OP_RM_AT    = 4'd8;
	localparam logic [3:0] OP_SEARCH   = 4'd9;
	localparam logic [3:0] OP_SORT_UP  = 4'd10;
	localparam logic [3:0] OP_SORT_DN  = 4'd11;
	localparam logic [3:0] OP_CLEAR    = 4'd12;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BADIDX   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [3:0]        operation;
		logic [4:0]        position;
		logic signed [7:0] value;
	} ibl_req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic signed [7:0] data;
		logic [4:0]        match_index;
		logic [5:0]        length;
		logic              last;
	} ibl_rsp_t;
endpackage

### rtl/core/indexed_byte_list_engine_top.sv
// Top level of the indexed byte list engine.
//  channel | signals               | transfer
//  request | start, busy, request  | start && !busy
//  result  | result_valid, result  | result_valid (one cycle, no stall)
// Size, clear, unused codes and errors found at the transfer: busy stays low, result in the cycle after the transfer.
// Get/edit: read, then result. Insert at p: each element from the tail down to p moves up one place (read, write).
// Remove at p: each later element moves down one place (read, write). Search: one read and compare per element;
// all matches but the last come out while busy is high. Sort: each element is compared with every later one.
// Reset empties the list; the receiver cannot stall, so nothing else holds the engine.
module indexed_byte_list_engine_top import ibl_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ibl_req_t request,
	output logic     busy,
	output logic     result_valid,
	output ibl_rsp_t result
);
	ibl_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .req(request),
		.busy(busy), .result_valid(result_valid), .result(result)
	);
endmodule

### rtl/core/ibl_seq.sv
// Sequencer: walks the element memory for each request; a new request is taken only while idle.
`include "indexed_byte_list_engine_top_defines.svh"
module ibl_seq import ibl_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ibl_req_t req,
	output logic     busy,
	output logic     result_valid,
	output ibl_rsp_t result
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDI  = 4'd1;
	localparam logic [3:0] S_GD   = 4'd2;
	localparam logic [3:0] S_INR  = 4'd3;
	localparam logic [3:0] S_INW  = 4'd4;
	localparam logic [3:0] S_RMC  = 4'd5;
	localparam logic [3:0] S_SHR  = 4'd6;
	localparam logic [3:0] S_SHW  = 4'd7;
	localparam logic [3:0] S_SCMP = 4'd8;
	localparam logic [3:0] S_SFIN = 4'd9;
	localparam logic [3:0] S_LDA  = 4'd10;
	localparam logic [3:0] S_RDJ  = 4'd11;
	localparam logic [3:0] S_CMP  = 4'd12;
	localparam logic [3:0] S_WBI  = 4'd13;

	logic [7:0]    mem [CAPACITY];
	logic [7:0]    rdata_q;
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, end_q, end_d, pend_q, pend_d;
	logic [3:0]    op_q, op_d;
	logic [7:0]    val_q, val_d, a_q, a_d, d_q, d_d;
	logic [5:0]    nres_q, nres_d;
	ibl_rsp_t      rsp_d;
	logic          rv_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	logic [PW-1:0] pos_w, cnt_w;
	logic [CW-1:0] last_idx;
	logic [7:0]    ka, kb;
	logic          swap_c, eq_c, is_sort;
	logic          clr_acc, rsp_err;

	assign busy     = (state_q != S_IDLE);
	assign pos_w    = PW'(req.position);
	assign cnt_w    = PW'(cnt_q);
	assign last_idx = cnt_q - CW'(1);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// shared compare: signed ordering via offset binary
	assign ka      = a_q ^ 8'h80;
	assign kb      = rdata_q ^ 8'h80;
	assign swap_c  = (op_q == OP_SORT_DN) ? (ka < kb) : (ka > kb);
	assign eq_c    = (rdata_q == val_q);
	assign is_sort = (op_q == OP_SORT_UP) || (op_q == OP_SORT_DN);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		j_d     = j_q;
		end_d   = end_q;
		pend_d  = pend_q;
		op_d    = op_q;
		val_d   = val_q;
		a_d     = a_q;
		d_d     = d_q;
		nres_d  = nres_q;
		rsp_d   = result;
		rv_d    = 1'b0;
		we      = 1'b0;
		waddr   = i_q[AW-1:0];
		wdata   = rdata_q;
		raddr   = i_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d   = req.operation;
					val_d  = req.value;
					nres_d = '0;
					rsp_d  = '{status: ST_OK, data: '0, match_index: '0,
						length: 6'(cnt_q), last: 1'b1};
					unique case (req.operation)
						OP_GET, OP_EDIT: begin
							if (cnt_q == '0) begin
								rsp_d.status = ST_EMPTY;
								rv_d         = 1'b1;
							end else if (pos_w >= cnt_w) begin
								rsp_d.status = ST_BADIDX;
								rv_d         = 1'b1;
							end else begin
								i_d     = pos_w[CW-1:0];
								state_d = S_RDI;
							end
						end
						OP_INS_TAIL, OP_INS_HEAD: begin
							if (cnt_q >= CW'(CAPACITY)) begin
								rsp_d.status = ST_FULL;
								rv_d         = 1'b1;
							end else begin
								i_d     = cnt_q;
								end_d   = (req.operation == OP_INS_TAIL) ? cnt_q : '0;
								state_d = S_INR;
							end
						end
						OP_INS_AT: begin
							if (pos_w >= cnt_w) begin
								rsp_d.status = ST_BADIDX;
								rv_d         = 1'b1;
							end else if (cnt_q >= CW'(CAPACITY)) begin
								rsp_d.status = ST_FULL;
								rv_d         = 1'b1;
							end else begin
								i_d     = cnt_q;
								end_d   = pos_w[CW-1:0];
								state_d = S_INR;
							end
						end
						OP_RM_TAIL, OP_RM_HEAD: begin
							if (cnt_q == '0) begin
								rsp_d.status = ST_EMPTY;
								rv_d         = 1'b1;
							end else begin
								i_d     = (req.operation == OP_RM_TAIL) ? last_idx : '0;
								state_d = S_RDI;
							end
						end
						OP_RM_AT: begin
							if (pos_w >= cnt_w) begin
								rsp_d.status = ST_BADIDX;
								rv_d         = 1'b1;
							end else begin
								i_d     = pos_w[CW-1:0];
								state_d = S_RDI;
							end
						end
						OP_SEARCH: begin
							if (cnt_q == '0) begin
								rsp_d.status = ST_EMPTY;
								rv_d         = 1'b1;
							end else begin
								i_d     = '0;
								state_d = S_RDI;
							end
						end
						OP_SORT_UP, OP_SORT_DN: begin
							if (cnt_q == '0) begin
								rsp_d.status = ST_EMPTY;
								rv_d         = 1'b1;
							end else if (cnt_q == CW'(1)) begin
								rv_d = 1'b1;
							end else begin
								i_d     = '0;
								j_d     = CW'(1);
								state_d = S_RDI;
							end
						end
						OP_CLEAR: begin
							cnt_d        = '0;
							rsp_d.length = '0;
							rv_d         = 1'b1;
						end
						default: begin
							rv_d = 1'b1;
						end
					endcase
				end
			end
			S_RDI: begin
				if (op_q == OP_GET || op_q == OP_EDIT) state_d = S_GD;
				else if (op_q == OP_SEARCH) state_d = S_SCMP;
				else if (is_sort) state_d = S_LDA;
				else state_d = S_RMC;
			end
			S_GD: begin
				rsp_d.data = rdata_q;
				rv_d       = 1'b1;
				state_d    = S_IDLE;
				if (op_q == OP_EDIT) begin
					we    = 1'b1;
					wdata = val_q;
				end
			end
			S_INR: begin
				raddr   = AW'(i_q - CW'(1));
				state_d = S_INW;
			end
			S_INW: begin
				we    = 1'b1;
				wdata = (i_q == end_q) ? val_q : rdata_q;
				if (i_q == end_q) begin
					cnt_d        = cnt_q + CW'(1);
					rsp_d.length = 6'(cnt_q + CW'(1));
					rv_d         = 1'b1;
					state_d      = S_IDLE;
				end else begin
					i_d     = i_q - CW'(1);
					state_d = S_INR;
				end
			end
			S_RMC: begin
				d_d = rdata_q;
				if (i_q + CW'(1) >= cnt_q) begin
					cnt_d        = last_idx;
					rsp_d.length = 6'(last_idx);
					rsp_d.data   = rdata_q;
					rv_d         = 1'b1;
					state_d      = S_IDLE;
				end else begin
					raddr   = AW'(i_q + CW'(1));
					state_d = S_SHW;
				end
			end
			S_SHW: begin
				we      = 1'b1;
				i_d     = i_q + CW'(1);
				state_d = S_SHR;
			end
			S_SHR: begin
				if (i_q + CW'(1) >= cnt_q) begin
					cnt_d        = last_idx;
					rsp_d.length = 6'(last_idx);
					rsp_d.data   = d_q;
					rv_d         = 1'b1;
					state_d      = S_IDLE;
				end else begin
					raddr   = AW'(i_q + CW'(1));
					state_d = S_SHW;
				end
			end
			S_SCMP: begin
				if (eq_c) begin
					if (nres_q != '0) begin
						rsp_d = '{status: ST_OK, data: val_q, match_index: 5'(pend_q),
							length: 6'(cnt_q), last: 1'b0};
						rv_d  = 1'b1;
					end
					pend_d = i_q;
					nres_d = nres_q + 6'd1;
				end
				if ((eq_c && nres_q == 6'(MAX_RESULTS - 1)) || i_q == last_idx) begin
					state_d = S_SFIN;
				end else begin
					i_d     = i_q + CW'(1);
					state_d = S_RDI;
				end
			end
			S_SFIN: begin
				rv_d    = 1'b1;
				state_d = S_IDLE;
				if (nres_q == '0) begin
					rsp_d = '{status: ST_NOTFOUND, data: '0, match_index: '0,
						length: 6'(cnt_q), last: 1'b1};
				end else begin
					rsp_d = '{status: ST_OK, data: val_q, match_index: 5'(pend_q),
						length: 6'(cnt_q), last: 1'b1};
				end
			end
			S_LDA: begin
				a_d     = rdata_q;
				raddr   = j_q[AW-1:0];
				state_d = S_CMP;
			end
			S_RDJ: begin
				raddr   = j_q[AW-1:0];
				state_d = S_CMP;
			end
			S_CMP: begin
				if (swap_c) begin
					we    = 1'b1;
					waddr = j_q[AW-1:0];
					wdata = a_q;
					a_d   = rdata_q;
				end
				if (j_q == last_idx) begin
					state_d = S_WBI;
				end else begin
					j_d     = j_q + CW'(1);
					state_d = S_RDJ;
				end
			end
			S_WBI: begin
				we    = 1'b1;
				wdata = a_q;
				if (i_q + CW'(2) >= cnt_q) begin
					rv_d    = 1'b1;
					state_d = S_IDLE;
				end else begin
					i_d     = i_q + CW'(1);
					j_d     = i_q + CW'(2);
					state_d = S_RDI;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			end_q        <= '0;
			pend_q       <= '0;
			op_q         <= '0;
			val_q        <= '0;
			a_q          <= '0;
			d_q          <= '0;
			nres_q       <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			i_q          <= i_d;
			j_q          <= j_d;
			end_q        <= end_d;
			pend_q       <= pend_d;
			op_q         <= op_d;
			val_q        <= val_d;
			a_q          <= a_d;
			d_q          <= d_d;
			nres_q       <= nres_d;
			result_valid <= rv_d;
			result       <= rsp_d;
		end
	end

	assign clr_acc = start && !busy && (req.operation == OP_CLEAR);
	assign rsp_err = result_valid && (result.status != ST_OK);

	`IBL_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "count over capacity")
	`IBL_ASSERT_NEXT(a_clr, clk, arst_n, clr_acc, result_valid && !(|result.length), "clear length")
	`IBL_ASSERT_IMP(a_we_busy, clk, arst_n, we, busy, "memory write while idle")
	`IBL_ASSERT_IMP(a_err_last, clk, arst_n, rsp_err, result.last, "error result not last")
endmodule

### tb/tb_indexed_byte_list_engine_top.sv
// Testbench of the indexed byte list engine: directed and random requests checked against a list model.
module tb_indexed_byte_list_engine_top;
	import ibl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 3000000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	ibl_req_t request = '0;
	logic     busy;
	logic     result_valid;
	ibl_rsp_t result;

	logic signed [7:0] list_mem [CAP];
	int                list_len = 0;
	ibl_rsp_t          pending_rsp [$];
	int                errors = 0;
	int                cycles = 0;
	int                idle_pct = 0;

	indexed_byte_list_engine_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .result_valid(result_valid), .result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	always @(posedge clk) begin
		ibl_rsp_t exp_rsp;
		if (arst_n && result_valid) begin
			if (pending_rsp.size() == 0) begin
				report($sformatf("unexpected result %p", result));
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (result.status !== exp_rsp.status)
					report($sformatf("status %0d want %0d", result.status, exp_rsp.status));
				if (result.data !== exp_rsp.data)
					report($sformatf("data %0d want %0d", result.data, exp_rsp.data));
				if (result.match_index !== exp_rsp.match_index)
					report($sformatf("match_index %0d want %0d", result.match_index,
						exp_rsp.match_index));
				if (result.length !== exp_rsp.length)
					report($sformatf("length %0d want %0d", result.length, exp_rsp.length));
				if (result.last !== exp_rsp.last)
					report($sformatf("last %0d want %0d", result.last, exp_rsp.last));
			end
		end
	end

	function automatic ibl_rsp_t make_rsp(logic [2:0] st, logic signed [7:0] d,
			logic [4:0] idx, logic lst);
		ibl_rsp_t r;
		r.status = st;
		r.data = d;
		r.match_index = idx;
		r.length = list_len[5:0];
		r.last = lst;
		return r;
	endfunction

	function automatic void list_insert(int pos, logic signed [7:0] v);
		for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
		list_mem[pos] = v;
		list_len++;
	endfunction

	function automatic logic signed [7:0] list_remove(int pos);
		logic signed [7:0] v;
		v = list_mem[pos];
		for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
		list_len--;
		return v;
	endfunction

	function automatic void predict_list_op(ibl_req_t rq);
		logic [2:0]        st;
		logic signed [7:0] d;
		logic signed [7:0] t;
		int                hits;
		logic              descending;
		st = ST_OK;
		d = '0;
		hits = 0;
		case (rq.operation)
			OP_GET, OP_EDIT: begin
				if (list_len == 0) st = ST_EMPTY;
				else if (rq.position >= list_len) st = ST_BADIDX;
				else begin
					d = list_mem[rq.position];
					if (rq.operation == OP_EDIT) list_mem[rq.position] = rq.value;
				end
			end
			OP_INS_TAIL, OP_INS_HEAD: begin
				if (list_len >= CAP) st = ST_FULL;
				else list_insert(rq.operation == OP_INS_TAIL ? list_len : 0, rq.value);
			end
			OP_INS_AT: begin
				if (rq.position >= list_len) st = ST_BADIDX;
				else if (list_len >= CAP) st = ST_FULL;
				else list_insert(rq.position, rq.value);
			end
			OP_RM_TAIL, OP_RM_HEAD: begin
				if (list_len == 0) st = ST_EMPTY;
				else d = list_remove(rq.operation == OP_RM_TAIL ? list_len - 1 : 0);
			end
			OP_RM_AT: begin
				if (rq.position >= list_len) st = ST_BADIDX;
				else d = list_remove(rq.position);
			end
			OP_SEARCH: begin
				if (list_len == 0) st = ST_EMPTY;
				else begin
					for (int i = 0; i < list_len && hits < MAX_RESULTS; i++)
						if (list_mem[i] == rq.value) begin
							pending_rsp.push_back(make_rsp(ST_OK, rq.value, i[4:0], 1'b0));
							hits++;
						end
					if (hits == 0) st = ST_NOTFOUND;
					else pending_rsp[pending_rsp.size()-1].last = 1'b1;
				end
			end
			OP_SORT_UP, OP_SORT_DN: begin
				if (list_len == 0) st = ST_EMPTY;
				else begin
					descending = (rq.operation == OP_SORT_DN);
					for (int i = 0; i + 1 < list_len; i++)
						for (int j = i + 1; j < list_len; j++)
							if (descending ? (list_mem[i] < list_mem[j])
									: (list_mem[i] > list_mem[j])) begin
								t = list_mem[i];
								list_mem[i] = list_mem[j];
								list_mem[j] = t;
							end
				end
			end
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
		if (hits == 0) pending_rsp.push_back(make_rsp(st, d, '0, 1'b1));
	endfunction

	task automatic send_request(input logic [3:0] op, input logic [4:0] pos,
			input logic signed [7:0] v);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		start = 1'b1;
		request = '{operation: op, position: pos, value: v};
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_list_op('{operation: op, position: pos, value: v});
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic test_empty_list();
		for (int op = 0; op < 16; op++) send_request(op[3:0], 5'd0, 8'sd0);
		send_request(OP_RM_AT, 5'd31, -8'sd128);
	endtask

	task automatic test_edges();
		send_request(OP_INS_TAIL, 5'd0, 8'sd127);
		send_request(OP_INS_HEAD, 5'd0, -8'sd128);
		send_request(OP_INS_AT, 5'd1, -8'sd1);
		send_request(OP_INS_AT, 5'd3, 8'sd5);
		send_request(OP_GET, 5'd2, 8'sd0);
		send_request(OP_GET, 5'd31, 8'sd0);
		send_request(OP_EDIT, 5'd0, 8'sd127);
		send_request(OP_EDIT, 5'd9, 8'sd0);
		send_request(OP_SEARCH, 5'd0, 8'sd127);
		send_request(OP_SEARCH, 5'd0, 8'sd3);
		send_request(OP_SORT_UP, 5'd0, 8'sd0);
		send_request(OP_SORT_DN, 5'd0, 8'sd0);
		send_request(OP_RM_AT, 5'd1, 8'sd0);
		send_request(OP_RM_TAIL, 5'd0, 8'sd0);
		send_request(OP_RM_HEAD, 5'd0, 8'sd0);
		send_request(OP_CLEAR, 5'd0, 8'sd0);
	endtask

	task automatic test_full_list();
		while (list_len < CAP) send_request(OP_INS_TAIL, 5'd0, 8'sd7);
		send_request(OP_INS_TAIL, 5'd0, 8'sd1);
		send_request(OP_INS_HEAD, 5'd0, 8'sd1);
		send_request(OP_INS_AT, 5'd31, 8'sd1);
		send_request(OP_SEARCH, 5'd0, 8'sd7);
		send_request(OP_SIZE, 5'd0, 8'sd0);
		drain_results();
	endtask

	task automatic test_random(input int count, input int pct);
		logic [3:0] op;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			op = $urandom_range(99) < 3 ? 4'($urandom_range(15)) :
				4'($urandom_range(OP_SORT_DN));
			if (list_len < 6 && $urandom_range(1)) op = OP_INS_TAIL;
			if (list_len > 28 && $urandom_range(1)) op = OP_RM_HEAD;
			if ($urandom_range(199) == 0) op = OP_CLEAR;
			send_request(op,
				$urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(list_len)),
				$urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(3)));
		end
		idle_pct = 0;
		drain_results();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_empty_list();
		test_edges();
		test_full_list();
		test_random(90, 0);
		test_random(90, 71);
		test_random(90, 15);
		test_random(90, 0);
		drain_results();
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/ibl_pkg.sv
rtl/core/ibl_seq.sv
rtl/core/indexed_byte_list_engine_top.sv
tb/tb_indexed_byte_list_engine_top.sv
